/* hdl/wialu_pkg.sv */
package wialu_pkg;

	localparam int LOW_BITS   = 64;
	localparam int HIGH_BITS  = 32;
	localparam int FIELD_BITS = LOW_BITS + HIGH_BITS;
	localparam int EXT_BITS   = 128;
	localparam int REQ_BITS   = 2;
	localparam int IN_BITS    = 2 * FIELD_BITS;
	localparam int OUT_BITS   = 104;

	typedef enum logic [REQ_BITS-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_t;

endpackage

/* hdl/wide_integer_alu_96.sv */
// Multiply and divide take one operand bit per cycle through the shared adder;
// add and subtract take a single step. A transaction is loaded, stepped and
// finished into the output register, and a new one is taken only after the
// last has finished; a result waits in the output register
// while the next transaction is taken.
// Reset: arst_n clears the sequencer and the output valid asynchronously.
module wide_integer_alu_96 #(
	parameter int WORD_BITS = 96
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// a_low, a_high, b_low, b_high
	input  logic [wialu_pkg::IN_BITS-1:0]    s_axis_tdata,
	// req_type
	input  logic [wialu_pkg::REQ_BITS-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// result_low, result_high, overflow, divide_by_zero, zero fill
	output logic [wialu_pkg::OUT_BITS-1:0]   m_axis_tdata
);
	import wialu_pkg::*;

	localparam int W = WORD_BITS;

	ctrl_t                ctrl;
	op_t                  op;
	logic [EXT_BITS-1:0]  a_ext;
	logic [EXT_BITS-1:0]  b_ext;
	logic [W-1:0]         result;
	logic [EXT_BITS-1:0]  r_ext;
	logic                 ovf;
	logic                 dbz;
	logic                 out_free;
	logic                 m_valid_q;
	logic [OUT_BITS-1:0]  m_data_q;

	assign op    = op_t'(s_axis_tuser);
	assign a_ext = EXT_BITS'(s_axis_tdata[FIELD_BITS-1:0]);
	assign b_ext = EXT_BITS'(s_axis_tdata[IN_BITS-1:FIELD_BITS]);

	assign out_free = !m_valid_q || m_axis_tready;

	wialu_seq #(.W(W)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.op       (op),
		.out_free (out_free),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	wialu_dp #(.W(W)) u_dp (
		.clk    (clk),
		.ctrl   (ctrl),
		.op     (op),
		.a_in   (a_ext[W-1:0]),
		.b_in   (b_ext[W-1:0]),
		.result (result),
		.ovf    (ovf),
		.dbz    (dbz)
	);

	assign r_ext = EXT_BITS'(result);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			m_data_q <= {(OUT_BITS - FIELD_BITS - 2)'(0), dbz, ovf,
				r_ext[FIELD_BITS-1:0]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> (!m_valid_q || m_axis_tready))
		else $error("result written over a pending output transaction");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !ctrl.finish)
		else $error("result finished in the cycle after acceptance");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q[FIELD_BITS+1]) |->
		(m_data_q[FIELD_BITS:0] == '0))
		else $error("divide by zero with nonzero result or overflow");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second transaction accepted while busy");

endmodule

/* hdl/wialu_dp.sv */
module wialu_dp #(
	parameter int W = 96
) (
	input  logic                  clk,
	input  wialu_pkg::ctrl_t      ctrl,
	input  wialu_pkg::op_t        op,
	input  logic [W-1:0]          a_in,
	input  logic [W-1:0]          b_in,
	output logic [W-1:0]          result,
	output logic                  ovf,
	output logic                  dbz
);
	import wialu_pkg::*;

	op_t          op_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] sh_q;
	logic [W-1:0] b_q;
	logic         ovf_q;
	logic         lost_q;
	logic         dbz_q;

	logic [W+1:0] x;
	logic [W+1:0] y;
	logic [W+1:0] sum;
	logic         sub;
	logic         ge;

	// One shared adder serves every operation; multiply and divide use it
	// once per operand bit.
	always_comb begin
		sub = (op_q == OP_SUB) || (op_q == OP_DIV);
		x   = {2'b00, acc_q};
		y   = {2'b00, b_q};
		if (op_q == OP_DIV) begin
			x = {1'b0, acc_q, sh_q[W-1]};
		end
		if (op_q == OP_MUL) begin
			y = {2'b00, sh_q};
		end
		sum = sub ? (x - y) : (x + y);
		ge  = !sum[W+1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q   <= op;
			acc_q  <= (op == OP_ADD || op == OP_SUB) ? a_in : '0;
			sh_q   <= a_in;
			b_q    <= b_in;
			ovf_q  <= 1'b0;
			lost_q <= 1'b0;
			dbz_q  <= (op == OP_DIV) && (b_in == '0);
		end else if (ctrl.step) begin
			case (op_q)
				OP_ADD: begin
					acc_q <= sum[W-1:0];
					ovf_q <= sum[W];
				end
				OP_SUB: begin
					acc_q <= sum[W-1:0];
				end
				OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= sum[W-1:0];
						ovf_q <= ovf_q | sum[W] | lost_q;
					end
					lost_q <= lost_q | sh_q[W-1];
					sh_q   <= {sh_q[W-2:0], 1'b0};
					b_q    <= {1'b0, b_q[W-1:1]};
				end
				default: begin
					// Restoring step: keep the shifted remainder unless the
					// divisor fits, and shift the quotient bit in behind the
					// dividend.
					acc_q <= ge ? sum[W-1:0] : x[W-1:0];
					sh_q  <= {sh_q[W-2:0], ge};
				end
			endcase
		end
	end

	always_comb begin
		if (dbz_q) begin
			result = '0;
		end else if (op_q == OP_DIV) begin
			result = sh_q;
		end else begin
			result = acc_q;
		end
		ovf = ovf_q;
		dbz = dbz_q;
	end

endmodule

/* hdl/wialu_seq.sv */
module wialu_seq #(
	parameter int W = 96
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  wialu_pkg::op_t   op,
	input  logic             out_free,
	output logic             in_ready,
	output wialu_pkg::ctrl_t ctrl
);
	import wialu_pkg::*;

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] cnt_q;
	logic          iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iter_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q  <= '0;
				iter_q <= (op == OP_MUL) || (op == OP_DIV);
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.step   = 1'b0;
		ctrl.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl.step = 1'b1;
				if (!iter_q || cnt_q == LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
